// ===== design/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg
// shared constants, state encoding and controller/datapath interface structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fir_pkg;

   localparam int MAX_TAPS_DEF  = 64;
   localparam int COEF_BITS_DEF = 16;

   localparam int SAMPLE_W    = 14;
   localparam int COEF_IN_W   = 16;
   localparam int COEF_IDX_W  = 6;
   localparam int TAPCNT_W    = 7;
   localparam int OUT_MAX     = 16383;

   localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 7'd16;

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } fir_state_type;

   typedef struct packed {
      logic start;
      logic coef_write;
      logic issue;
      logic load_out;
   } fir_cmd_type;

   typedef struct packed {
      logic last_tap;
      logic pipe_busy;
   } fir_sts_type;

endpackage

// ===== design/fir_filter_circular.sv =====
// ----------------------------------------------------------------------------
// fir_filter_circular
// direct-form fir filter on a circular delay line, one mac per tap per cycle
// ----------------------------------------------------------------------------
// a filter transaction is taken only while idle, one sample at a time: the
//   single shared mac steps through the delay line and coefficient rams one
//   tap a cycle and the mac pipe drains; the result is then loaded into the
//   output register, raising rsp_valid, later while an earlier result waits
// a coefficient write gives no result
// reset (synchronous, active high) clears the tap count to 16, the write
//   pointer and the per-entry valid bits; unwritten entries read as zero
`timescale 1ns / 1ps

module fir_filter_circular
   import fir_pkg::*;
#(
   parameter int MAX_TAPS  = MAX_TAPS_DEF,
   parameter int COEF_BITS = COEF_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [SAMPLE_W-1:0]         req_sample,
   input  logic [COEF_IDX_W-1:0]       req_coef_index,
   input  logic signed [COEF_IN_W-1:0] req_coef_value,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [SAMPLE_W-1:0]         rsp_filtered_sample,
   // tap count register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [TAPCNT_W-1:0]         csr_tap_count
);

   fir_cmd_type cmd;
   fir_sts_type sts;
   logic        csr_write;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequencer: one transaction in flight, result parked in output register
   fir_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   // rams, mac pipe (read, multiply, accumulate) and output saturation
   fir_datapath #(
      .MAX_TAPS  (MAX_TAPS),
      .COEF_BITS (COEF_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_tap_count       (csr_tap_count),
      .req_sample          (req_sample),
      .req_coef_index      (req_coef_index),
      .req_coef_value      (req_coef_value),
      .rsp_filtered_sample (rsp_filtered_sample),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

// ===== design/fir_ram.sv =====
// ----------------------------------------------------------------------------
// fir_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fir_ctrl.sv =====
// ----------------------------------------------------------------------------
// fir_ctrl
// sequencer: accepts transactions, steps the tap loop, hands off the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_ctrl
   import fir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output fir_cmd_type cmd,
   input  fir_sts_type sts
);

   fir_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               if (req_command == CMD_COEF) begin
                  cmd.coef_write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (sts.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy && out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !sts.pipe_busy)
      else $error("mac pipeline busy while idle");

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !sts.pipe_busy)
      else $error("result loaded before accumulation finished");

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("result raised outside drain");

endmodule

// ===== design/fir_datapath.sv =====
// ----------------------------------------------------------------------------
// fir_datapath
// delay line and coefficient rams, multiply-accumulate pipe, output saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_datapath
   import fir_pkg::*;
#(
   parameter int MAX_TAPS  = MAX_TAPS_DEF,
   parameter int COEF_BITS = COEF_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [TAPCNT_W-1:0]         csr_tap_count,
   input  logic [SAMPLE_W-1:0]         req_sample,
   input  logic [COEF_IDX_W-1:0]       req_coef_index,
   input  logic signed [COEF_IN_W-1:0] req_coef_value,
   output logic [SAMPLE_W-1:0]         rsp_filtered_sample,
   input  fir_cmd_type                 cmd,
   output fir_sts_type                 sts
);

   localparam int AW     = $clog2(MAX_TAPS);
   localparam int TW     = $clog2(MAX_TAPS + 1);
   localparam int CWI    = (COEF_BITS < COEF_IN_W) ? COEF_BITS : COEF_IN_W;
   localparam int PROD_W = SAMPLE_W + COEF_BITS;
   localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_TAPS);
   // rounding half plus midscale folded into the starting value
   localparam logic signed [ACC_W-1:0] ACC_INIT =
      ACC_W'((64'sd1 <<< (COEF_BITS - 2)) + (64'sd8192 <<< (COEF_BITS - 1)));

   logic [TAPCNT_W-1:0]     tap_count_ff;
   logic [TW-1:0]           taps_ff, taps_in;
   logic [AW-1:0]           wp_ff, wp_next;
   logic [AW-1:0]           pos_ff, pos_next;
   logic [AW-1:0]           k_ff;
   logic [MAX_TAPS-1:0]     dvalid_ff, cvalid_ff;
   logic                    vq_ff;
   logic                    s1_ff, s2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] ysh;
   logic [SAMPLE_W-1:0]     out_ff, out_in;

   logic                    coef_ok;
   logic [AW-1:0]           coef_addr;
   logic [COEF_BITS-1:0]    coef_wdata;
   logic [SAMPLE_W-1:0]     dl_wdata;
   logic [SAMPLE_W-1:0]     dl_q;
   logic [COEF_BITS-1:0]    cf_q;
   logic signed [SAMPLE_W-1:0]  d_op;
   logic signed [COEF_BITS-1:0] c_op;

   // offset binary to two's complement: flip the msb
   assign dl_wdata   = {~req_sample[SAMPLE_W-1], req_sample[SAMPLE_W-2:0]};
   assign coef_ok    = 32'(req_coef_index) < MAX_TAPS;
   assign coef_addr  = AW'(req_coef_index);
   assign coef_wdata = COEF_BITS'($signed(req_coef_value[CWI-1:0]));

   assign wp_next  = (wp_ff == AW'(MAX_TAPS - 1)) ? '0 : wp_ff + 1'b1;
   assign pos_next = (pos_ff == '0) ? AW'(MAX_TAPS - 1) : pos_ff - 1'b1;

   always_comb begin
      if (tap_count_ff == '0) begin
         taps_in = TW'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         taps_in = TW'(MAX_TAPS);
      end else begin
         taps_in = TW'(tap_count_ff);
      end
   end

   fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_delay_ram (
      .clock   (clock),
      .wr_en   (cmd.start),
      .wr_addr (wp_ff),
      .wr_data (dl_wdata),
      .rd_addr (pos_ff),
      .rd_data (dl_q)
   );

   fir_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.coef_write && coef_ok),
      .wr_addr (coef_addr),
      .wr_data (coef_wdata),
      .rd_addr (k_ff),
      .rd_data (cf_q)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAPCNT_RESET;
         wp_ff        <= '0;
         dvalid_ff    <= '0;
         cvalid_ff    <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
      end else begin
         if (csr_write) begin
            tap_count_ff <= csr_tap_count;
         end
         if (cmd.start) begin
            wp_ff            <= wp_next;
            dvalid_ff[wp_ff] <= 1'b1;
         end
         if (cmd.coef_write && coef_ok) begin
            cvalid_ff[coef_addr] <= 1'b1;
         end
         s1_ff <= cmd.issue;
         s2_ff <= s1_ff;
      end
   end

   assign d_op    = $signed(dl_q);
   assign c_op    = $signed(cf_q);

   // signed product, zero for entries never written
   always_comb begin
      if (vq_ff) begin
         prod_in = d_op * c_op;
      end else begin
         prod_in = '0;
      end
   end

   assign ysh = acc_ff >>> (COEF_BITS - 1);

   always_comb begin
      if (ysh < 0) begin
         out_in = '0;
      end else if (ysh > ACC_W'(OUT_MAX)) begin
         out_in = SAMPLE_W'(OUT_MAX);
      end else begin
         out_in = ysh[SAMPLE_W-1:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_ff  <= wp_ff;
         k_ff    <= '0;
         taps_ff <= taps_in;
      end else if (cmd.issue) begin
         pos_ff <= pos_next;
         k_ff   <= k_ff + 1'b1;
      end
      // entries never written read as zero
      vq_ff   <= dvalid_ff[pos_ff] && cvalid_ff[k_ff];
      prod_ff <= prod_in;
      if (cmd.start) begin
         acc_ff <= ACC_INIT;
      end else if (s2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   assign sts.last_tap      = (TW'(k_ff) + 1'b1) == taps_ff;
   assign sts.pipe_busy     = s1_ff || s2_ff;
   assign rsp_filtered_sample = out_ff;

endmodule
